// ===== rtl/core/record_message_deframer_top_defines.svh =====
// Assertion macros for the record message deframer checker.
// Used by rmd_checker.sv; no other dependencies.
`ifndef RECORD_MESSAGE_DEFRAMER_TOP_DEFINES_SVH
`define RECORD_MESSAGE_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmd checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmd checker: next-cycle property failed");

`endif

// ===== rtl/core/rmd_pkg.sv =====
// Shared types and constants for the record message deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rmd_pkg;

  localparam int MAGIC_LEN   = 4;
  localparam int OUT_TDATA_W = 152;

  localparam logic [MAGIC_LEN-1:0][7:0] MAGIC_BYTES = {8'h00, 8'h47, 8'h53, 8'h4D};

  // Result parts of one command, in emission order
  localparam int PART_LEAD   = 0;
  localparam int PART_RECEND = 1;
  localparam int PART_OK     = 2;
  localparam int PART_TRUNC  = 3;
  localparam int PARTS       = 4;

  typedef enum logic [3:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_MAGIC2,
    PH_MAGIC3,
    PH_VERSION,
    PH_FLAGS,
    PH_COUNT_LO,
    PH_COUNT_HI,
    PH_TYPE_LO,
    PH_TYPE_HI,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_IDLE
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_HEADER,
    KIND_RECHDR,
    KIND_PAYLOAD,
    KIND_RECEND,
    KIND_OK,
    KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_TRUNC
  } err_e;

  typedef struct packed {
    kind_e       lead;
    logic        has_recend;
    logic        has_ok;
    logic        has_trunc;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [15:0] count;
    logic [15:0] rtype;
    logic [15:0] rlen;
    logic [7:0]  pbyte;
    logic [15:0] poff;
    logic [23:0] csum;
    logic [31:0] total;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [1:0]  error_code;
    logic [31:0] total_payload;
    logic [23:0] checksum;
    logic [15:0] payload_offset;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic [15:0] record_type;
    logic [15:0] record_count;
    logic [7:0]  flags;
    logic [7:0]  version;
  } out_data_t;

endpackage
`default_nettype wire

// ===== rtl/core/rmd_front.sv =====
// Front end: accepts buffer bytes, tracks the parse phase and issues commands.
// Depends on rmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [7:0]    in_data_i,
  input  wire logic          in_last_i,
  input  wire logic          full_i,
  output logic               in_ready_o,
  output logic               push_o,
  output rmd_pkg::cmd_t      cmd_o
);

  rmd_pkg::phase_e phase_q, phase_d, phase_nx;
  logic [3:0]  phase_bits;
  logic [7:0]  version_q, version_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] left_q, left_d;
  logic [15:0] type_q, type_d;
  logic [15:0] length_q, length_d;
  logic [15:0] offset_q, offset_d;
  logic [23:0] sum_q, sum_d;
  logic [31:0] total_q, total_d;

  logic        fire;
  logic [15:0] word;
  logic [15:0] offset_inc;
  logic [15:0] left_dec;
  logic [23:0] sum_inc;
  logic [31:0] total_acc;
  logic        magic_ok;
  logic        zero_count;
  logic        rec_done;
  logic        msg_done;
  logic        settled;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && !full_i;
  assign phase_bits = phase_q;
  assign word       = {in_data_i, hold_q};
  assign offset_inc = offset_q + 16'd1;
  assign left_dec   = left_q - 16'd1;
  assign sum_inc    = sum_q + {16'd0, in_data_i};
  assign total_acc  = (phase_q == rmd_pkg::PH_LEN_HI) ? total_q + {16'd0, word} : total_q;
  assign magic_ok   = in_data_i == rmd_pkg::MAGIC_BYTES[phase_bits[1:0]];
  assign zero_count = (phase_q == rmd_pkg::PH_COUNT_HI) && (word == 16'd0);
  assign rec_done   = ((phase_q == rmd_pkg::PH_LEN_HI) && (word == 16'd0)) ||
                      ((phase_q == rmd_pkg::PH_PAYLOAD) && (offset_inc == length_q));
  assign msg_done   = rec_done && (left_dec == 16'd0);
  assign settled    = phase_nx == rmd_pkg::PH_IDLE;

  // Next state
  always_comb begin
    case (phase_q)
      rmd_pkg::PH_MAGIC0:   phase_nx = magic_ok ? rmd_pkg::PH_MAGIC1 : rmd_pkg::PH_IDLE;
      rmd_pkg::PH_MAGIC1:   phase_nx = magic_ok ? rmd_pkg::PH_MAGIC2 : rmd_pkg::PH_IDLE;
      rmd_pkg::PH_MAGIC2:   phase_nx = magic_ok ? rmd_pkg::PH_MAGIC3 : rmd_pkg::PH_IDLE;
      rmd_pkg::PH_MAGIC3:   phase_nx = magic_ok ? rmd_pkg::PH_VERSION : rmd_pkg::PH_IDLE;
      rmd_pkg::PH_VERSION:  phase_nx = rmd_pkg::PH_FLAGS;
      rmd_pkg::PH_FLAGS:    phase_nx = rmd_pkg::PH_COUNT_LO;
      rmd_pkg::PH_COUNT_LO: phase_nx = rmd_pkg::PH_COUNT_HI;
      rmd_pkg::PH_COUNT_HI: phase_nx = zero_count ? rmd_pkg::PH_IDLE : rmd_pkg::PH_TYPE_LO;
      rmd_pkg::PH_TYPE_LO:  phase_nx = rmd_pkg::PH_TYPE_HI;
      rmd_pkg::PH_TYPE_HI:  phase_nx = rmd_pkg::PH_LEN_LO;
      rmd_pkg::PH_LEN_LO:   phase_nx = rmd_pkg::PH_LEN_HI;
      rmd_pkg::PH_LEN_HI, rmd_pkg::PH_PAYLOAD: begin
        if (msg_done) begin
          phase_nx = rmd_pkg::PH_IDLE;
        end else if (rec_done) begin
          phase_nx = rmd_pkg::PH_TYPE_LO;
        end else begin
          phase_nx = rmd_pkg::PH_PAYLOAD;
        end
      end
      default:              phase_nx = rmd_pkg::PH_IDLE;
    endcase
    phase_d = phase_q;
    if (fire) begin
      phase_d = in_last_i ? rmd_pkg::PH_MAGIC0 : phase_nx;
    end
  end

  // Outputs and datapath updates
  always_comb begin
    version_d = version_q;
    flags_d   = flags_q;
    hold_d    = hold_q;
    left_d    = left_q;
    type_d    = type_q;
    length_d  = length_q;
    offset_d  = offset_q;
    sum_d     = sum_q;
    total_d   = total_q;
    cmd_o     = '0;
    cmd_o.lead = rmd_pkg::KIND_NONE;
    if (fire) begin
      case (phase_q)
        rmd_pkg::PH_MAGIC0, rmd_pkg::PH_MAGIC1,
        rmd_pkg::PH_MAGIC2, rmd_pkg::PH_MAGIC3: begin
          if (!magic_ok) begin
            cmd_o.lead = rmd_pkg::KIND_ERROR;
          end
        end
        rmd_pkg::PH_VERSION: version_d = in_data_i;
        rmd_pkg::PH_FLAGS:   flags_d = in_data_i;
        rmd_pkg::PH_COUNT_LO, rmd_pkg::PH_TYPE_LO, rmd_pkg::PH_LEN_LO: hold_d = in_data_i;
        rmd_pkg::PH_COUNT_HI: begin
          left_d       = word;
          cmd_o.lead   = rmd_pkg::KIND_HEADER;
          cmd_o.has_ok = zero_count;
        end
        rmd_pkg::PH_TYPE_HI: type_d = word;
        rmd_pkg::PH_LEN_HI: begin
          length_d         = word;
          offset_d         = 16'd0;
          sum_d            = 24'd0;
          left_d           = rec_done ? left_dec : left_q;
          cmd_o.lead       = rmd_pkg::KIND_RECHDR;
          cmd_o.has_recend = rec_done;
          cmd_o.has_ok     = msg_done;
        end
        rmd_pkg::PH_PAYLOAD: begin
          offset_d         = offset_inc;
          sum_d            = sum_inc;
          left_d           = rec_done ? left_dec : left_q;
          cmd_o.lead       = rmd_pkg::KIND_PAYLOAD;
          cmd_o.has_recend = rec_done;
          cmd_o.has_ok     = msg_done;
        end
        default: ;
      endcase
      total_d = in_last_i ? 32'd0 : total_acc;
    end
    cmd_o.has_trunc = in_last_i && !settled;
    cmd_o.version   = version_q;
    cmd_o.flags     = flags_q;
    cmd_o.count     = word;
    cmd_o.rtype     = type_q;
    cmd_o.rlen      = length_d;
    cmd_o.pbyte     = in_data_i;
    cmd_o.poff      = offset_q;
    cmd_o.csum      = sum_d;
    cmd_o.total     = total_acc;
    push_o = fire && ((cmd_o.lead != rmd_pkg::KIND_NONE) || cmd_o.has_trunc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rmd_pkg::PH_MAGIC0;
      total_q <= 32'd0;
    end else begin
      phase_q <= phase_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    version_q <= version_d;
    flags_q   <= flags_d;
    hold_q    <= hold_d;
    left_q    <= left_d;
    type_q    <= type_d;
    length_q  <= length_d;
    offset_q  <= offset_d;
    sum_q     <= sum_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/rmd_queue.sv =====
// Command queue between the front and back ends of the deframer.
// Depends on rmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmd_queue #(
  parameter int Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rmd_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rmd_pkg::cmd_t      data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  rmd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_ok) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rmd_back.sv =====
// Back end: expands each queued command into result transactions.
// Depends on rmd_pkg; drives the output register of the deframer.
`timescale 1ns / 1ps
`default_nettype none
module rmd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire rmd_pkg::cmd_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rmd_pkg::kind_e     out_kind_o,
  output rmd_pkg::out_data_t out_data_o,
  output logic               out_last_o
);

  logic [rmd_pkg::PARTS-1:0] parts, pending, pick, sent_q, sent_d;
  logic               valid_q, valid_d;
  logic               last_part, load;
  rmd_pkg::kind_e     kind_q, kind_d;
  rmd_pkg::out_data_t data_q, data_d;
  logic               last_q;

  assign parts[rmd_pkg::PART_LEAD]   = head_i.lead != rmd_pkg::KIND_NONE;
  assign parts[rmd_pkg::PART_RECEND] = head_i.has_recend;
  assign parts[rmd_pkg::PART_OK]     = head_i.has_ok;
  assign parts[rmd_pkg::PART_TRUNC]  = head_i.has_trunc;
  assign pending   = parts & ~sent_q;
  assign pick      = pending & (~pending + rmd_pkg::PARTS'(1));
  assign last_part = (pending & ~pick) == '0;
  assign load      = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o     = load && last_part;

  always_comb begin
    data_d = '0;
    kind_d = rmd_pkg::KIND_ERROR;
    if (pick[rmd_pkg::PART_LEAD]) begin
      kind_d = head_i.lead;
      case (head_i.lead)
        rmd_pkg::KIND_HEADER: begin
          data_d.version      = head_i.version;
          data_d.flags        = head_i.flags;
          data_d.record_count = head_i.count;
        end
        rmd_pkg::KIND_RECHDR: begin
          data_d.record_type    = head_i.rtype;
          data_d.payload_length = head_i.rlen;
        end
        rmd_pkg::KIND_PAYLOAD: begin
          data_d.record_type    = head_i.rtype;
          data_d.payload_length = head_i.rlen;
          data_d.payload_byte   = head_i.pbyte;
          data_d.payload_offset = head_i.poff;
        end
        rmd_pkg::KIND_ERROR: data_d.error_code = rmd_pkg::ERR_MAGIC;
        default: ;
      endcase
    end else if (pick[rmd_pkg::PART_RECEND]) begin
      kind_d                = rmd_pkg::KIND_RECEND;
      data_d.record_type    = head_i.rtype;
      data_d.payload_length = head_i.rlen;
      data_d.checksum       = head_i.csum;
    end else if (pick[rmd_pkg::PART_OK]) begin
      kind_d               = rmd_pkg::KIND_OK;
      data_d.total_payload = head_i.total;
    end else begin
      data_d.error_code = rmd_pkg::ERR_TRUNC;
    end
  end

  always_comb begin
    valid_d = valid_q;
    sent_d  = sent_q;
    if (load) begin
      valid_d = 1'b1;
      sent_d  = last_part ? '0 : (sent_q | pick);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= '0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      data_q <= data_d;
      last_q <= last_part;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/record_message_deframer_top.sv =====
// Record message deframer: takes a message buffer one byte per input
// transaction (tlast on the final byte) and returns header, record header,
// payload byte, record end, message ok and error results, up to three per
// byte, one result transaction per cycle. Input bytes are accepted every
// cycle while the command queue between front and back end has room; the
// back end emits one result per cycle while tready is high, so a byte with
// multiple results holds it until all are sent; sustained throughput is
// set by the result count. Results are queued, then registered. Result
// kinds on tuser: 1 header, 2 record header, 3 payload byte, 4 record end,
// 5 message ok, 6 error (error_code 1 bad magic, 2 truncated buffer).
// Depends on rmd_pkg, rmd_front, rmd_queue and rmd_back.
`timescale 1ns / 1ps
`default_nettype none
module record_message_deframer_top #(
  parameter int QueueDepth = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [7:0]                        s_axis_tdata_i,  // data_byte
  input  wire logic                              s_axis_tlast_i,  // end_of_buffer
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // version, flags, record_count, record_type, payload_length, payload_byte,
  // payload_offset, checksum, total_payload, error_code, zero fill
  output logic [rmd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  output logic [2:0]                             m_axis_tuser_o,  // result_kind
  output logic                                   m_axis_tlast_o   // last_of_run
);

  rmd_pkg::cmd_t      push_cmd, head_cmd;
  logic               push, full, head_valid, pop;
  rmd_pkg::kind_e     out_kind;
  rmd_pkg::out_data_t out_data;

  rmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .full_i     (full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  rmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_kind_o   (out_kind),
    .out_data_o   (out_data),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_data;
  assign m_axis_tuser_o = out_kind;

endmodule
`default_nettype wire

// ===== rtl/core/rmd_checker.sv =====
// Port-level checks on the result stream of the deframer, bound to the top.
// Depends on rmd_pkg and record_message_deframer_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "record_message_deframer_top_defines.svh"
module rmd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_kind_i,
  input wire logic       out_last_i
);

  `RMD_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RMD_ASSERT_IMPL(a_kind_known, clk_i, rst_ni, out_valid_i, (out_kind_i != rmd_pkg::KIND_NONE) && (out_kind_i <= rmd_pkg::KIND_ERROR))
  `RMD_ASSERT_IMPL(a_error_ends_run, clk_i, rst_ni, out_valid_i && (out_kind_i == rmd_pkg::KIND_ERROR), out_last_i)
  `RMD_ASSERT_IMPL(a_ok_ends_run, clk_i, rst_ni, out_valid_i && (out_kind_i == rmd_pkg::KIND_OK), out_last_i)

endmodule

bind record_message_deframer_top rmd_checker u_rmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (m_axis_tvalid_o),
  .out_ready_i (m_axis_tready_i),
  .out_kind_i  (m_axis_tuser_o),
  .out_last_i  (m_axis_tlast_o)
);
`default_nettype wire
